FILE: src/assert_macros.svh
// Assertion macros shared by the decoder's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: src/mpdd_pkg.sv
// Types and constants of the polyline delta decoder.
package mpdd_pkg;
    typedef struct packed {
        logic [7:0] data_byte;
        logic       record_start;
    } t_in;
    typedef struct packed {
        logic        result_kind;
        logic [6:0]  shape_type;
        logic        direction_flag;
        logic [21:0] label_offset;
        logic        label_in_net;
        logic [16:0] record_length;
        logic [31:0] point_lon;
        logic [31:0] point_lat;
        logic        last_point;
    } t_out;
    localparam logic [1:0] ADDR_CLON  = 2'd0;
    localparam logic [1:0] ADDR_CLAT  = 2'd1;
    localparam logic [1:0] ADDR_SHIFT = 2'd2;
    localparam logic [1:0] ADDR_MODE  = 2'd3;
    localparam logic [31:0] LON_CLAMP = 32'h007f_ffff;

    function automatic logic [4:0] width_of(input logic [3:0] base, input logic sgn);
        logic [4:0] w;
        w = 5'd2 + ((base <= 4'd9) ? {1'b0, base} : ({base, 1'b0} - 5'd9));
        return sgn ? w + 5'd1 : w;
    endfunction
endpackage

FILE: src/mpdd_out_fifo.sv
// Small result queue between the decoder core and the output channel.
module mpdd_out_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mpdd_pkg::t_out i_data,
    output logic [2:0]    o_count,
    output logic          o_valid,
    output mpdd_pkg::t_out o_data,
    input  logic          i_stall
);
    import mpdd_pkg::*;
    t_out r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic pop;
    assign pop = r_cnt != 3'd0 && !i_stall;
    assign o_valid = r_cnt != 3'd0;
    assign o_data = r_mem[r_rp];
    assign o_count = r_cnt;
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 2'd1;
            if (pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b0, i_push} - {2'b0, pop};
        end
    end
    `include "assert_macros.svh"
    `ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, (r_cnt < 3'd4) || pop)
    `ASSERT_NEXT(a_cnt_hold, i_clk, i_rst_n, !i_push && !pop, $stable(r_cnt))
    `ASSERT_IMPL(a_valid_cnt, i_clk, i_rst_n, o_valid, r_cnt <= 3'd4)
endmodule

FILE: src/map_polyline_delta_decoder.sv
// Top level of the polyline and polygon record delta decoder.
// One record byte is accepted at a time, and the input is stalled until that byte has been
// handled. The base-width byte that closes the header queues the header transaction and
// holds the first point back. A bitstream byte is shifted into the bit reservoir one bit a
// cycle. Each decoded point is then read from the reservoir one delta bit per cycle, and
// every escape chunk is read bit by bit and added to the escape sum. Results wait in a
// four-entry queue; the input is stalled while the queue holds more than one transaction,
// and decoding pauses while it holds more than two or one is being written.
module map_polyline_delta_decoder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  mpdd_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output mpdd_pkg::t_out o_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import mpdd_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LOAD  = 8'b0000_0010,
        S_PICK  = 8'b0000_0100,
        S_BIT   = 8'b0000_1000,
        S_VAL   = 8'b0001_0000,
        S_ADD   = 8'b0010_0000,
        S_EMIT  = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [23:0] r_clon, r_clat;
    logic [4:0]  r_cshift;
    logic        r_lmode;
    logic [1:0]  r_rec;
    logic [3:0]  r_hidx;
    logic [15:0] r_left;
    logic [63:0] r_buf;
    logic [6:0]  r_bcnt;
    logic [4:0]  r_xw, r_yw;
    logic [3:0]  r_smode;
    logic        r_ebf;
    logic [31:0] r_lon, r_lat, r_esc;
    logic [55:0] r_hf;
    logic [6:0]  r_type;
    logic        r_dir, r_two;
    logic [7:0]  r_base;
    logic [15:0] r_hlen;
    logic [1:0]  r_phase;
    logic        r_pv;
    logic [31:0] r_plon, r_plat;
    logic [4:0]  r_shift;
    logic        r_cneg;
    logic [7:0]  r_byte;
    logic [3:0]  r_ld;
    logic        r_ended;
    logic [4:0]  r_bi;
    logic [31:0] r_tmp, r_v;

    logic        push;
    t_out        pdata;
    logic [2:0]  fcnt;
    logic        acc;

    assign pready = 1'b1;
    assign o_stall = r_state != S_IDLE || fcnt > 3'd1;
    assign acc = i_valid && !o_stall;

    always_comb begin
        case (paddr[3:2])
            ADDR_CLON:  prdata = {8'd0, r_clon};
            ADDR_CLAT:  prdata = {8'd0, r_clat};
            ADDR_SHIFT: prdata = {27'd0, r_cshift};
            ADDR_MODE:  prdata = {31'd0, r_lmode};
            default:    prdata = '0;
        endcase
    end

    mpdd_out_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(pdata),
        .o_count(fcnt), .o_valid(o_valid), .o_data(o_data), .i_stall(i_stall)
    );

    logic [4:0]  cw;
    logic        csgn, cneg;
    logic [5:0]  bpc;
    logic [31:0] half;
    logic [23:0] lbl;
    logic [31:0] dlng, dlat;
    logic        fbyte_xs, fbyte_ys;

    assign cw   = (r_phase == 2'd1) ? r_xw : r_yw;
    assign csgn = (r_phase == 2'd1) ? r_smode[0] : r_smode[2];
    assign cneg = (r_phase == 2'd1) ? r_smode[1] : r_smode[3];
    assign bpc  = {1'b0, r_xw} + {1'b0, r_yw} + {5'd0, r_ebf};
    assign half = 32'd1 << (cw - 5'd1);
    assign lbl  = r_hf[23:0];
    assign dlng = {{16{r_hf[39]}}, r_hf[39:24]};
    assign dlat = {{16{r_hf[55]}}, r_hf[55:40]};
    assign fbyte_xs = i_data.data_byte[0];
    assign fbyte_ys = fbyte_xs ? i_data.data_byte[2] : i_data.data_byte[1];

    function automatic logic [31:0] clampf(input logic [31:0] v, input logic neg);
        return (!neg && v >= 32'h0080_0000 && v < 32'h8000_0000) ? LON_CLAMP : v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_clon <= '0; r_clat <= '0; r_cshift <= '0; r_lmode <= 1'b0;
            r_rec <= '0; r_hidx <= '0; r_left <= '0; r_pv <= 1'b0;
            r_phase <= '0; r_bcnt <= '0; r_buf <= '0;
            r_xw <= '0; r_yw <= '0; r_smode <= '0; r_ebf <= 1'b0;
            r_two <= 1'b0; r_hlen <= '0; r_hf <= '0;
            push <= 1'b0;
        end else begin
            push <= 1'b0;
            if (psel && penable && pwrite) begin
                case (paddr[3:2])
                    ADDR_CLON:  r_clon <= pwdata[23:0];
                    ADDR_CLAT:  r_clat <= pwdata[23:0];
                    ADDR_SHIFT: r_cshift <= pwdata[4:0];
                    ADDR_MODE:  r_lmode <= pwdata[0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (acc && (i_data.record_start || r_rec != 2'd0)) begin
                        if (i_data.record_start || r_rec == 2'd1) begin
                            if (i_data.record_start || r_hidx == 4'd0) begin
                                r_rec <= 2'd1; r_pv <= 1'b0; r_phase <= '0;
                                r_two <= i_data.data_byte[7];
                                r_type <= r_lmode ? {1'b0, i_data.data_byte[5:0]}
                                                  : i_data.data_byte[6:0];
                                r_dir <= r_lmode & i_data.data_byte[6];
                                r_hf <= '0; r_hlen <= '0; r_hidx <= 4'd1;
                            end else if (r_hidx <= 4'd7) begin
                                r_hf[{r_hidx[2:0] - 3'd1, 3'b000} +: 8] <= i_data.data_byte;
                                r_hidx <= r_hidx + 4'd1;
                            end else if (r_hidx == 4'd8) begin
                                r_hlen <= {8'd0, i_data.data_byte}; r_hidx <= 4'd9;
                            end else if (r_hidx == 4'd9 && r_two) begin
                                r_hlen[15:8] <= i_data.data_byte; r_hidx <= 4'd10;
                            end else begin
                                r_base <= i_data.data_byte; r_hidx <= 4'd0;
                                r_ebf <= lbl[22];
                                pdata <= '{result_kind: 1'b0, shape_type: r_type,
                                    direction_flag: r_dir, label_offset: lbl[21:0],
                                    label_in_net: lbl[23],
                                    record_length: 17'd10 + {1'b0, r_hlen}
                                                   + {16'd0, r_two},
                                    point_lon: '0, point_lat: '0, last_point: 1'b0};
                                push <= 1'b1;
                                r_shift <= r_cshift;
                                r_cneg <= r_clon[23];
                                r_lon <= clampf((dlng << r_cshift) + {8'd0, r_clon},
                                                r_clon[23]);
                                r_lat <= (dlat << r_cshift) + {{8{r_clat[23]}}, r_clat};
                                r_left <= r_hlen; r_buf <= '0; r_bcnt <= '0;
                                r_ended <= r_hlen == 16'd0;
                                r_pv <= 1'b0;
                                r_state <= S_EMIT;
                            end
                        end else if (r_rec == 2'd2) begin
                            r_smode <= {fbyte_ys & (fbyte_xs ? i_data.data_byte[3]
                                                             : i_data.data_byte[2]),
                                        !fbyte_ys,
                                        fbyte_xs & i_data.data_byte[1], !fbyte_xs};
                            r_xw <= width_of(r_base[3:0], !fbyte_xs);
                            r_yw <= width_of(r_base[7:4], !fbyte_ys);
                            r_byte <= i_data.data_byte >> (3'd2 + {2'd0, fbyte_xs}
                                                          + {2'd0, fbyte_ys});
                            r_ld <= 4'd6 - {3'd0, fbyte_xs} - {3'd0, fbyte_ys};
                            r_rec <= 2'd3;
                            r_left <= r_left - 16'd1;
                            r_ended <= r_left == 16'd1;
                            r_state <= S_LOAD;
                        end else begin
                            r_byte <= i_data.data_byte;
                            r_ld <= (r_bcnt <= 7'd56) ? 4'd8 : 4'd0;
                            r_left <= r_left - 16'd1;
                            r_ended <= r_left == 16'd1;
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    if (r_ld != 4'd0) begin
                        r_buf[r_bcnt[5:0]] <= r_byte[0];
                        r_byte <= r_byte >> 1;
                        r_bcnt <= r_bcnt + 7'd1;
                        r_ld <= r_ld - 4'd1;
                    end else begin
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    if (r_phase == 2'd0) begin
                        if (push || fcnt > 3'd2) begin
                            r_state <= S_PICK;
                        end else if ({1'b0, r_bcnt} < {2'b0, bpc}) begin
                            r_state <= r_ended ? S_FIN : S_IDLE;
                        end else begin
                            if (r_ebf) begin
                                r_buf <= r_buf >> 1;
                                r_bcnt <= (r_bcnt != 7'd0) ? r_bcnt - 7'd1 : 7'd0;
                            end
                            r_esc <= '0; r_phase <= 2'd1;
                        end
                    end else if (!r_ended && r_bcnt < {2'b0, cw}) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_tmp <= '0; r_bi <= '0; r_state <= S_BIT;
                    end
                end
                S_BIT: begin
                    if (r_bi == cw) begin
                        r_state <= S_VAL;
                    end else begin
                        r_tmp[r_bi] <= r_buf[0];
                        r_buf <= r_buf >> 1;
                        r_bcnt <= (r_bcnt != 7'd0) ? r_bcnt - 7'd1 : 7'd0;
                        r_bi <= r_bi + 5'd1;
                    end
                end
                S_VAL: begin
                    if (csgn && r_tmp == half) begin
                        r_esc <= r_esc + r_tmp - 32'd1;
                        r_state <= S_PICK;
                    end else begin
                        if (csgn) r_v <= (r_tmp < half) ? r_esc + r_tmp
                                                      : r_tmp - (half << 1) - r_esc;
                        else r_v <= cneg ? 32'd0 - r_tmp : r_tmp;
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    if (r_phase == 2'd1) begin
                        r_lon <= r_lon + (r_v << r_shift);
                        r_esc <= '0; r_phase <= 2'd2;
                        r_state <= S_PICK;
                    end else begin
                        r_lat <= r_lat + (r_v << r_shift);
                        r_lon <= clampf(r_lon, r_cneg);
                        r_phase <= 2'd0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (r_pv) begin
                        pdata <= '{result_kind: 1'b1, shape_type: '0,
                            direction_flag: 1'b0, label_offset: '0, label_in_net: 1'b0,
                            record_length: '0, point_lon: r_plon, point_lat: r_plat,
                            last_point: 1'b0};
                        push <= 1'b1;
                    end
                    r_pv <= 1'b1; r_plon <= r_lon; r_plat <= r_lat;
                    if (r_rec == 2'd1) begin
                        if (r_ended) r_state <= S_FIN;
                        else begin r_rec <= 2'd2; r_state <= S_IDLE; end
                    end else r_state <= S_PICK;
                end
                S_FIN: begin
                    if (r_pv) begin
                        pdata <= '{result_kind: 1'b1, shape_type: '0,
                            direction_flag: 1'b0, label_offset: '0, label_in_net: 1'b0,
                            record_length: '0, point_lon: r_plon, point_lat: r_plat,
                            last_point: 1'b1};
                        push <= 1'b1;
                    end
                    r_pv <= 1'b0; r_rec <= 2'd0; r_phase <= 2'd0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_stall_busy, i_clk, i_rst_n, r_state != S_IDLE, o_stall)
    `ASSERT_NEXT(a_fin_idle, i_clk, i_rst_n, r_state == S_FIN, r_rec == 2'd0)
    `ASSERT_IMPL(a_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_state))
endmodule
